>>> rtl/vcds_pkg.sv
// ----------------------------------------------------------------------------
// vcds_pkg
// Shared types, register codes and saturation helpers for the diffusion
// stencil.
// ----------------------------------------------------------------------------
package vcds_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DIMS       = 3'd0,
    REG_GRID_NX    = 3'd1,
    REG_GRID_NY    = 3'd2,
    REG_GRID_NZ    = 3'd3,
    REG_INV_DX1_SQ = 3'd4,
    REG_INV_DX2_SQ = 3'd5,
    REG_INV_DX3_SQ = 3'd6,
    REG_COUPLING   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] dims;
    logic [8:0] nx;
    logic [8:0] ny;
    logic [8:0] nz;
  } grid_cfg_t;

  // Per-cell bookkeeping that travels with an item
  typedef struct packed {
    logic [1:0] d;
    logic       emit;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] cz;
    logic       last;
  } cell_info_t;

  typedef struct packed {
    logic signed [47:0] val;
    logic               clip;
  } wide_sat_t;

  localparam logic signed [65:0] WIDE_MAX = 66'sh7FFF_FFFF_FFFF;
  localparam logic signed [65:0] WIDE_MIN = -66'sh7FFF_FFFF_FFFF;
  localparam logic signed [65:0] RES_MAX  = 66'sh7FFF_FFFF;
  localparam logic signed [65:0] RES_MIN  = -66'sh8000_0000;

  // Clip to +-(2^47-1)
  function automatic wide_sat_t sat_wide(input logic signed [65:0] v);
    wide_sat_t r;
    if (v > WIDE_MAX) begin
      r.val  = WIDE_MAX[47:0];
      r.clip = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.val  = WIDE_MIN[47:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[47:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/vcds_cell_if.sv
// ----------------------------------------------------------------------------
// vcds_cell_if
// Input channel: one grid cell per transfer.
// ----------------------------------------------------------------------------
interface vcds_cell_if;
  logic               valid;
  logic               ready;
  logic               start_of_grid;
  logic signed [31:0] field_value;
  logic [30:0]        conductivity;
  logic [30:0]        capacity;

  modport source(output valid, start_of_grid, field_value, conductivity, capacity,
                 input ready);
  modport sink(input valid, start_of_grid, field_value, conductivity, capacity,
               output ready);
endinterface

>>> rtl/vcds_result_if.sv
// ----------------------------------------------------------------------------
// vcds_result_if
// Output channel: one interior-cell result per transfer.
// ----------------------------------------------------------------------------
interface vcds_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [7:0]         cell_x;
  logic [7:0]         cell_y;
  logic [7:0]         cell_z;
  logic               last_cell;
  logic               saturated;

  modport source(output valid, result_value, cell_x, cell_y, cell_z, last_cell, saturated,
                 input ready);
  modport sink(input valid, result_value, cell_x, cell_y, cell_z, last_cell, saturated,
               output ready);
endinterface

>>> rtl/vcds_ram.sv
// ----------------------------------------------------------------------------
// vcds_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module vcds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> rtl/vcds_pos.sv
// ----------------------------------------------------------------------------
// vcds_pos
// Stream position tracking, interior test and store addressing.
// ----------------------------------------------------------------------------
module vcds_pos #(
  parameter int MAX_NX = 256,
  parameter int MAX_NY = 256,
  parameter int MAX_NZ = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                start,
  input  vcds_pkg::grid_cfg_t cfg,
  output vcds_pkg::cell_info_t info,
  output logic [$clog2(2*(MAX_NX+2)*(MAX_NY+2))-1:0] waddr,
  output logic [5:0][$clog2(2*(MAX_NX+2)*(MAX_NY+2))-1:0] raddr
);
  import vcds_pkg::*;

  localparam int SX = MAX_NX + 2;
  localparam int SY = MAX_NY + 2;
  localparam int AW = $clog2(2 * SX * SY);
  localparam int XW = $clog2(MAX_NX + 3);
  localparam int YW = $clog2(MAX_NY + 3);
  localparam int ZW = $clog2(MAX_NZ + 3);

  logic [XW-1:0] pos_x, pos_x_next, nx, ex, sx, px, cx;
  logic [YW-1:0] pos_y, pos_y_next, ny, ey, sy, py, cy;
  logic [ZW-1:0] pos_z, pos_z_next, nz, ez, sz, pz, cz;
  logic [1:0]    d;
  logic          emit;

  function automatic logic [AW-1:0] addr(input logic zb, input logic [XW-1:0] x,
                                         input logic [YW-1:0] y);
    return AW'((32'(zb) * SY + 32'(y)) * SX + 32'(x));
  endfunction

  always_comb begin
    d = (cfg.dims == 2'd0) ? 2'd1 : cfg.dims;

    if (cfg.nx == 9'd0) nx = XW'(1);
    else if (32'(cfg.nx) > MAX_NX) nx = XW'(MAX_NX);
    else nx = XW'(cfg.nx);

    if (d < 2'd2 || cfg.ny == 9'd0) ny = YW'(1);
    else if (32'(cfg.ny) > MAX_NY) ny = YW'(MAX_NY);
    else ny = YW'(cfg.ny);

    if (d != 2'd3 || cfg.nz == 9'd0) nz = ZW'(1);
    else if (32'(cfg.nz) > MAX_NZ) nz = ZW'(MAX_NZ);
    else nz = ZW'(cfg.nz);

    ex = nx + XW'(2);
    ey = (d >= 2'd2) ? ny + YW'(2) : YW'(1);
    ez = (d == 2'd3) ? nz + ZW'(2) : ZW'(1);

    // Start of grid forces the position back to the corner
    sx = start ? '0 : pos_x;
    sy = start ? '0 : pos_y;
    sz = start ? '0 : pos_z;
    px = (sx < ex) ? sx : '0;
    py = (sy < ey) ? sy : '0;
    pz = (sz < ez) ? sz : '0;

    // Center cell lags the input by one step along the slowest active axis
    case (d)
      2'd3: begin
        cx = px;
        cy = py;
        cz = pz - ZW'(pz != '0);
        emit = pz >= ZW'(2);
      end
      2'd2: begin
        cx = px;
        cy = py - YW'(py != '0);
        cz = '0;
        emit = py >= YW'(2);
      end
      default: begin
        cx = px - XW'(px != '0);
        cy = '0;
        cz = '0;
        emit = px >= XW'(2);
      end
    endcase
    emit = emit && cx >= XW'(1) && cx <= nx;
    if (d >= 2'd2) emit = emit && cy >= YW'(1) && cy <= ny;
    if (d == 2'd3) emit = emit && cz <= nz;

    info.d    = d;
    info.emit = emit;
    info.cx   = 8'(XW'(cx - XW'(1)));
    info.cy   = (d >= 2'd2) ? 8'(YW'(cy - YW'(1))) : 8'd0;
    info.cz   = (d == 2'd3) ? 8'(ZW'(cz - ZW'(1))) : 8'd0;
    info.last = cx == nx && (d < 2'd2 || cy == ny) && (d < 2'd3 || cz == nz);

    waddr    = addr(pz[0], px, py);
    raddr[0] = addr(cz[0], cx, cy);
    raddr[1] = addr(cz[0], cx - XW'(1), cy);
    raddr[2] = addr(cz[0], cx + XW'(1), cy);
    raddr[3] = addr(cz[0], cx, cy - YW'(1));
    raddr[4] = addr(cz[0], cx, cy + YW'(1));
    raddr[5] = addr(~cz[0], cx, cy);

    // Advance in raster order, wrap at the end of the padded grid
    pos_x_next = px + XW'(1);
    pos_y_next = py;
    pos_z_next = pz;
    if (pos_x_next >= ex) begin
      pos_x_next = '0;
      pos_y_next = py + YW'(1);
      if (pos_y_next >= ey) begin
        pos_y_next = '0;
        pos_z_next = pz + ZW'(1);
        if (pos_z_next >= ez) pos_z_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

endmodule

>>> rtl/vcds_axis.sv
// ----------------------------------------------------------------------------
// vcds_axis
// One axis term: face conductivities, flux difference and 1/dx^2 scaling.
// ----------------------------------------------------------------------------
module vcds_axis (
  input  logic               clk,
  input  logic [4:0]         en,
  input  logic signed [31:0] fm,
  input  logic signed [31:0] fc,
  input  logic signed [31:0] fp,
  input  logic [30:0]        km,
  input  logic [30:0]        kc,
  input  logic [30:0]        kp,
  input  logic [30:0]        inv,
  output logic signed [47:0] term,
  output logic               flag
);
  import vcds_pkg::*;

  logic [30:0]        kfp_a, kfm_a;
  logic signed [32:0] dp_a, dm_a;
  logic signed [63:0] pp_b, pm_b;
  logic signed [47:0] diff_c;
  logic               flag_c, flag_d;
  logic signed [63:0] ph_d;
  logic [30:0]        pl_d;
  logic [31:0]        kfp_sum, kfm_sum;
  logic [46:0]        pl_full;
  wide_sat_t          diff_sat, term_sat;

  always_comb begin
    kfp_sum  = 32'(kc) + 32'(kp);
    kfm_sum  = 32'(kc) + 32'(km);
    diff_sat = sat_wide(66'(pp_b >>> 16) - 66'(pm_b >>> 16));
    pl_full  = 47'(diff_c[15:0]) * 47'(inv);
    term_sat = sat_wide(66'(ph_d) + 66'($signed({1'b0, pl_d})));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kfp_a <= kfp_sum[31:1];
      kfm_a <= kfm_sum[31:1];
      dp_a  <= 33'(fp) - 33'(fc);
      dm_a  <= 33'(fc) - 33'(fm);
    end
    if (en[1]) begin
      pp_b <= 64'(dp_a) * 64'($signed({1'b0, kfp_a}));
      pm_b <= 64'(dm_a) * 64'($signed({1'b0, kfm_a}));
    end
    if (en[2]) begin
      diff_c <= diff_sat.val;
      flag_c <= diff_sat.clip;
    end
    // Split the wide operand into a signed high word and an unsigned low word
    if (en[3]) begin
      ph_d   <= 64'($signed(diff_c[47:16])) * 64'($signed({1'b0, inv}));
      pl_d   <= pl_full[46:16];
      flag_d <= flag_c;
    end
    if (en[4]) begin
      term <= term_sat.val;
      flag <= flag_d | term_sat.clip;
    end
  end

endmodule

>>> rtl/variable_coefficient_diffusion_stencil.sv
// ----------------------------------------------------------------------------
// variable_coefficient_diffusion_stencil
// Streaming 7-point variable-coefficient Laplacian with capacity term.
// ----------------------------------------------------------------------------
// Cells arrive in raster order (x fastest) over the interior plus one ghost
// layer on each active axis; each interior cell yields one result once its
// last neighbor has arrived, giving capacity*field minus coupling_factor times
// the face-averaged Laplacian, saturated to Q16.16 with a flag. The block
// takes one cell per clock cycle unless a full pipeline meets a blocked
// output. The pipeline has nine register stages, the first loaded at the
// transfer of the cell that completes a neighborhood and the last holding
// the result offered on the output. The rate is set by the store: two planes
// of cells sit in six RAM copies, each written with every cell and each read
// at one stencil address per cycle, so all seven stencil points come out
// together. Ghost cells produce no result. The stores need no clearing after
// reset: every read that leads to a result hits an entry that the current
// grid has written. Configure only while the pipeline is empty.
// ----------------------------------------------------------------------------
module variable_coefficient_diffusion_stencil #(
  parameter int MAX_NX = 256,
  parameter int MAX_NY = 256,
  parameter int MAX_NZ = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  vcds_cell_if.sink   cells,
  vcds_result_if.source results
);
  import vcds_pkg::*;

  localparam int DEPTH = 2 * (MAX_NX + 2) * (MAX_NY + 2);
  localparam int AW    = $clog2(DEPTH);
  localparam int NS    = 9;

  // Configuration registers
  grid_cfg_t          grid;
  logic [30:0]        inv_dx1_sq, inv_dx2_sq, inv_dx3_sq;
  logic signed [31:0] coupling_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid.dims       <= 2'd3;
      grid.nx         <= 9'd256;
      grid.ny         <= 9'd256;
      grid.nz         <= 9'd256;
      inv_dx1_sq      <= 31'd65536;
      inv_dx2_sq      <= 31'd65536;
      inv_dx3_sq      <= 31'd65536;
      coupling_factor <= 32'sd0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIMS:       grid.dims       <= cfg_data[1:0];
        REG_GRID_NX:    grid.nx         <= cfg_data[8:0];
        REG_GRID_NY:    grid.ny         <= cfg_data[8:0];
        REG_GRID_NZ:    grid.nz         <= cfg_data[8:0];
        REG_INV_DX1_SQ: inv_dx1_sq      <= cfg_data[30:0];
        REG_INV_DX2_SQ: inv_dx2_sq      <= cfg_data[30:0];
        REG_INV_DX3_SQ: inv_dx3_sq      <= cfg_data[30:0];
        REG_COUPLING:   coupling_factor <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage advances when empty or when the next
  // stage advances, so bubbles collapse under back-pressure.
  logic [NS:1]   v;
  logic [NS+1:1] adv;
  logic          accept;

  always_comb begin
    adv[NS+1] = results.ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign cells.ready = adv[1];
  assign accept      = cells.valid && adv[1];

  // Position, interior test and addressing
  cell_info_t           info0;
  logic [AW-1:0]        waddr;
  logic [5:0][AW-1:0]   raddr;

  vcds_pos #(.MAX_NX(MAX_NX), .MAX_NY(MAX_NY), .MAX_NZ(MAX_NZ)) u_pos (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .start (cells.start_of_grid),
    .cfg   (grid),
    .info  (info0),
    .waddr (waddr),
    .raddr (raddr)
  );

  // Plane stores: center copy keeps capacity too, neighbor copies only f and k.
  // Reads are read-first, so a cell sees the store before its own write.
  logic [93:0] rd0;
  logic [62:0] rdn [1:5];

  vcds_ram #(.WIDTH(94), .DEPTH(DEPTH)) u_ram_c (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata({cells.capacity, cells.conductivity, cells.field_value}),
    .re   (accept),
    .raddr(raddr[0]),
    .rdata(rd0)
  );

  for (genvar i = 1; i <= 5; i++) begin : g_nb
    vcds_ram #(.WIDTH(63), .DEPTH(DEPTH)) u_ram_n (
      .clk  (clk),
      .we   (accept),
      .waddr(waddr),
      .wdata({cells.conductivity, cells.field_value}),
      .re   (accept),
      .raddr(raddr[i]),
      .rdata(rdn[i])
    );
  end

  // Stage 1: incoming cell alongside the store read data
  cell_info_t         info_q [1:NS];
  logic signed [31:0] fin1;
  logic [30:0]        kin1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= accept && info0.emit;
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      info_q[1] <= info0;
      fin1      <= cells.field_value;
      kin1      <= cells.conductivity;
    end
    for (int k = 2; k <= NS; k++) begin
      if (adv[k]) info_q[k] <= info_q[k-1];
    end
  end

  // Operand selection: the incoming cell is the far neighbor on the slowest axis
  logic signed [31:0] f0, f1, f2, f3, f4, f5, fpx, fpy;
  logic [30:0]        k0, k1, k2, k3, k4, k5, kpx, kpy, cap0;

  always_comb begin
    f0   = $signed(rd0[31:0]);
    k0   = rd0[62:32];
    cap0 = rd0[93:63];
    f1   = $signed(rdn[1][31:0]);
    k1   = rdn[1][62:32];
    f2   = $signed(rdn[2][31:0]);
    k2   = rdn[2][62:32];
    f3   = $signed(rdn[3][31:0]);
    k3   = rdn[3][62:32];
    f4   = $signed(rdn[4][31:0]);
    k4   = rdn[4][62:32];
    f5   = $signed(rdn[5][31:0]);
    k5   = rdn[5][62:32];
    fpx  = (info_q[1].d == 2'd1) ? fin1 : f2;
    kpx  = (info_q[1].d == 2'd1) ? kin1 : k2;
    fpy  = (info_q[1].d == 2'd2) ? fin1 : f4;
    kpy  = (info_q[1].d == 2'd2) ? kin1 : k4;
  end

  // Stages 2 to 6: axis terms
  logic signed [47:0] tx, ty, tz;
  logic               flx, fly, flz;

  vcds_axis u_ax_x (
    .clk(clk), .en(adv[6:2]),
    .fm(f1), .fc(f0), .fp(fpx), .km(k1), .kc(k0), .kp(kpx), .inv(inv_dx1_sq),
    .term(tx), .flag(flx)
  );

  vcds_axis u_ax_y (
    .clk(clk), .en(adv[6:2]),
    .fm(f3), .fc(f0), .fp(fpy), .km(k3), .kc(k0), .kp(kpy), .inv(inv_dx2_sq),
    .term(ty), .flag(fly)
  );

  vcds_axis u_ax_z (
    .clk(clk), .en(adv[6:2]),
    .fm(f5), .fc(f0), .fp(fin1), .km(k5), .kc(k0), .kp(kin1), .inv(inv_dx3_sq),
    .term(tz), .flag(flz)
  );

  // Capacity product runs alongside: stage 2 holds operands, stage 3 the product
  logic signed [31:0] fc2;
  logic [30:0]        cap2;
  logic signed [47:0] fcap_q [3:8];
  logic signed [62:0] fcap_full;

  assign fcap_full = 63'(fc2) * 63'($signed({1'b0, cap2}));

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      fc2  <= f0;
      cap2 <= cap0;
    end
    if (adv[3]) fcap_q[3] <= 48'(fcap_full >>> 16);
    for (int k = 4; k <= 8; k++) begin
      if (adv[k]) fcap_q[k] <= fcap_q[k-1];
    end
  end

  // Stage 7: sum the active axis terms
  logic signed [47:0] lap7;
  logic               fl7;
  wide_sat_t          lap_sat;
  logic               use_y, use_z;

  always_comb begin
    use_y   = info_q[6].d >= 2'd2;
    use_z   = info_q[6].d == 2'd3;
    lap_sat = sat_wide(66'(tx) + (use_y ? 66'(ty) : 66'sd0) + (use_z ? 66'(tz) : 66'sd0));
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      lap7 <= lap_sat.val;
      fl7  <= flx | (use_y & fly) | (use_z & flz) | lap_sat.clip;
    end
  end

  // Stage 8: coupling product split into high and low partials
  logic signed [63:0] qh8;
  logic signed [31:0] ql8;
  logic               fl8;
  logic signed [47:0] ql_full;

  assign ql_full = 48'($signed({1'b0, lap7[15:0]})) * 48'(coupling_factor);

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      qh8 <= 64'($signed(lap7[47:16])) * 64'(coupling_factor);
      ql8 <= $signed(ql_full[47:16]);
      fl8 <= fl7;
    end
  end

  // Stage 9: combine, clip to 32 bits, output register
  logic signed [65:0] res_full;
  logic signed [31:0] res9;
  logic               sat9;

  assign res_full = 66'(fcap_q[8]) - (66'(qh8) + 66'(ql8));

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      if (res_full > RES_MAX) begin
        res9 <= RES_MAX[31:0];
        sat9 <= 1'b1;
      end else if (res_full < RES_MIN) begin
        res9 <= RES_MIN[31:0];
        sat9 <= 1'b1;
      end else begin
        res9 <= res_full[31:0];
        sat9 <= fl8;
      end
    end
  end

  assign results.valid        = v[NS];
  assign results.result_value = res9;
  assign results.cell_x       = info_q[NS].cx;
  assign results.cell_y       = info_q[NS].cy;
  assign results.cell_z       = info_q[NS].cz;
  assign results.last_cell    = info_q[NS].last;
  assign results.saturated    = sat9;

`ifndef SYNTH
  // Input stalls only when every stage is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> (&v) && !results.ready)
    else $error("input stalled with a bubble in the pipeline");

  // An interior cell enters stage 1 right after its transfer
  a_emit_enters: assert property (@(posedge clk) disable iff (rst)
    accept && info0.emit |=> v[1])
    else $error("interior cell lost at pipeline entry");

  // Store read data holds while stage 1 is stalled
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    v[1] && !adv[1] |=> v[1] && $stable(rd0))
    else $error("store read data changed during stall");

  // Ghost cells never reach the pipeline
  a_ghost_drop: assert property (@(posedge clk) disable iff (rst)
    accept && !info0.emit && adv[1] |=> !v[1])
    else $error("ghost cell entered the pipeline");
`endif

endmodule
